/* hdl/jpn_pkg.sv */
package jpn_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int FRAC_BITS   = 14;
    localparam int ONE         = 1 << FRAC_BITS;
    localparam int SMALL_MUL   = 200;

    // Deviation and its square
    localparam int AW    = SAMPLE_BITS;
    localparam int DEVW  = SAMPLE_BITS + 1;
    localparam int SQW   = 2 * AW;
    localparam int SUMW  = 2 * AW + 1;

    // Length square root
    localparam int LQW   = (SUMW + 2 * FRAC_BITS + 1) / 2;
    localparam int LQRAD = 2 * LQW;
    localparam int MAGW  = LQW - FRAC_BITS;

    // Direction division and square root
    localparam int DQW   = 2 * FRAC_BITS + 1;
    localparam int DRW   = FRAC_BITS + 1;
    localparam int DRAD  = 2 * DRW;
    localparam int DIRW  = FRAC_BITS + 2;

    // Gate maximum
    localparam int RW    = SAMPLE_BITS;
    localparam int OFFD  = SAMPLE_BITS + 1;
    localparam int PW    = OFFD + DIRW;
    localparam int CORRW = PW + 1;
    localparam int PRW   = 2 * DRW + SUMW;
    localparam int SMW   = DRW + 8;
    localparam int BNW   = RW + 2 * FRAC_BITS;
    localparam int BDW   = DRW;
    localparam int TW    = BNW + 2;
    localparam int MW    = BNW + 1;

    // Amplitude factor
    localparam int KW    = 16;
    localparam int KNW   = LQW + FRAC_BITS;

    // Pipeline depths
    localparam int N_DDIV = DQW;
    localparam int N_LQ   = LQW;
    localparam int N_DSQ  = DRW;
    localparam int N_BDIV = BNW;
    localparam int N_KDIV = KW;

    // Ports
    localparam int IN_TDW  = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_FW  = KW + 2 * DIRW + MAGW;
    localparam int OUT_TDW = ((OUT_FW + 7) / 8) * 8;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = SAMPLE_BITS;

    localparam logic [CFG_AW-1:0] REG_OFFSET_X = 3'd0;
    localparam logic [CFG_AW-1:0] REG_OFFSET_Y = 3'd1;
    localparam logic [CFG_AW-1:0] REG_DEAD_X   = 3'd2;
    localparam logic [CFG_AW-1:0] REG_DEAD_Y   = 3'd3;
    localparam logic [CFG_AW-1:0] REG_REACH_X  = 3'd4;
    localparam logic [CFG_AW-1:0] REG_REACH_Y  = 3'd5;
    localparam logic [CFG_AW-1:0] REG_AXIS_EN  = 3'd6;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] offset_x;
        logic [SAMPLE_BITS-1:0] offset_y;
        logic [SAMPLE_BITS-1:0] dead_x;
        logic [SAMPLE_BITS-1:0] dead_y;
        logic [SAMPLE_BITS-1:0] reach_x;
        logic [SAMPLE_BITS-1:0] reach_y;
        logic [1:0]             axis_en;
    } cfg_t;

    typedef struct packed {
        logic [SQW-1:0]  ax2;
        logic [SQW-1:0]  ay2;
        logic [SUMW-1:0] sum;
        logic            negx;
        logic            negy;
    } front_word_t;

    typedef struct packed {
        logic signed [DIRW-1:0] c;
        logic signed [DIRW-1:0] s;
        logic [LQW-1:0]         lq;
    } polar_word_t;

    typedef struct packed {
        logic [MW-1:0]          m;
        logic signed [DIRW-1:0] c;
        logic signed [DIRW-1:0] s;
        logic [LQW-1:0]         lq;
    } gate_word_t;

    typedef struct packed {
        logic [MAGW-1:0]        magnitude;
        logic signed [DIRW-1:0] dir_sin;
        logic signed [DIRW-1:0] dir_cos;
        logic [KW-1:0]          amp_factor;
    } result_t;

endpackage

/* hdl/jpn_front.sv */
module jpn_front import jpn_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  logic                   in_valid,
    input  logic [SAMPLE_BITS-1:0] raw_x,
    input  logic [SAMPLE_BITS-1:0] raw_y,
    input  cfg_t                   cfg,
    output logic                   out_valid,
    output front_word_t            out_word
);

    // {negative, magnitude} of the dead-zoned deviation
    function automatic logic [AW:0] dev_mag(
        input logic [SAMPLE_BITS-1:0] raw,
        input logic [SAMPLE_BITS-1:0] off,
        input logic [SAMPLE_BITS-1:0] dead,
        input logic                   en
    );
        logic [DEVW-1:0] d;
        logic [DEVW-1:0] a;
        logic            neg;
        d   = {1'b0, raw} - {1'b0, off};
        neg = d[DEVW-1];
        a   = neg ? (~d + 1'b1) : d;
        if (!en || (a[AW-1:0] <= dead))
            return '0;
        return {neg, a[AW-1:0]};
    endfunction

    logic [AW:0] x_dev;
    logic [AW:0] y_dev;

    logic            s1_valid_reg;
    logic [AW-1:0]   ax_reg;
    logic [AW-1:0]   ay_reg;
    logic            nx1_reg;
    logic            ny1_reg;
    logic            s2_valid_reg;
    logic [SQW-1:0]  ax2_reg;
    logic [SQW-1:0]  ay2_reg;
    logic            nx2_reg;
    logic            ny2_reg;
    logic            out_valid_reg;
    front_word_t     out_word_reg;

    always_comb
    begin
        x_dev = dev_mag(raw_x, cfg.offset_x, cfg.dead_x, cfg.axis_en[0]);
        y_dev = dev_mag(raw_y, cfg.offset_y, cfg.dead_y, cfg.axis_en[1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax_reg  <= x_dev[AW-1:0];
            nx1_reg <= x_dev[AW];
            ay_reg  <= y_dev[AW-1:0];
            ny1_reg <= y_dev[AW];

            ax2_reg <= SQW'(ax_reg) * SQW'(ax_reg);
            ay2_reg <= SQW'(ay_reg) * SQW'(ay_reg);
            nx2_reg <= nx1_reg;
            ny2_reg <= ny1_reg;

            out_word_reg.ax2  <= ax2_reg;
            out_word_reg.ay2  <= ay2_reg;
            out_word_reg.sum  <= SUMW'(ax2_reg) + SUMW'(ay2_reg);
            out_word_reg.negx <= nx2_reg;
            out_word_reg.negy <= ny2_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

/* hdl/jpn_polar.sv */
module jpn_polar import jpn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        in_valid,
    input  front_word_t in_word,
    output logic        out_valid,
    output polar_word_t out_word
);

    // One restoring division step: {rem, quotient shift}
    function automatic logic [SUMW+DQW-1:0] ddiv_step(
        input logic [SUMW-1:0] rem,
        input logic [DQW-1:0]  low,
        input logic [SUMW-1:0] den
    );
        logic [SUMW:0] t;
        logic          q;
        t = {rem, low[DQW-1]};
        q = (t >= {1'b0, den});
        if (q)
            t = t - {1'b0, den};
        return {t[SUMW-1:0], low[DQW-2:0], q};
    endfunction

    // One square root digit of the length: {rem, root, radicand}
    function automatic logic [LQW+1+LQW+LQRAD-1:0] lq_step(
        input logic [LQW:0]       rem,
        input logic [LQW-1:0]     root,
        input logic [LQRAD-1:0]   rad
    );
        logic [LQW+2:0] cand;
        logic [LQW+2:0] trial;
        logic [LQW-1:0] nroot;
        cand  = {rem, rad[LQRAD-1 -: 2]};
        trial = {1'b0, root, 2'b01};
        nroot = {root[LQW-2:0], 1'b0};
        if (cand >= trial)
        begin
            cand  = cand - trial;
            nroot = {root[LQW-2:0], 1'b1};
        end
        return {cand[LQW:0], nroot, rad[LQRAD-3:0], 2'b00};
    endfunction

    // One square root digit of a direction component
    function automatic logic [DRW+1+DRW+DRAD-1:0] dsq_step(
        input logic [DRW:0]     rem,
        input logic [DRW-1:0]   root,
        input logic [DRAD-1:0]  rad
    );
        logic [DRW+2:0] cand;
        logic [DRW+2:0] trial;
        logic [DRW-1:0] nroot;
        cand  = {rem, rad[DRAD-1 -: 2]};
        trial = {1'b0, root, 2'b01};
        nroot = {root[DRW-2:0], 1'b0};
        if (cand >= trial)
        begin
            cand  = cand - trial;
            nroot = {root[DRW-2:0], 1'b1};
        end
        return {cand[DRW:0], nroot, rad[DRAD-3:0], 2'b00};
    endfunction

    logic [SUMW-1:0]  init_crem;
    logic [DQW-1:0]   init_clow;
    logic [SUMW-1:0]  init_srem;
    logic [DQW-1:0]   init_slow;
    logic [LQRAD-1:0] init_lrad;

    // Division section
    logic             dv_reg    [N_DDIV];
    logic [SUMW-1:0]  crem_reg  [N_DDIV];
    logic [DQW-1:0]   clow_reg  [N_DDIV];
    logic [SUMW-1:0]  srem_reg  [N_DDIV];
    logic [DQW-1:0]   slow_reg  [N_DDIV];
    logic [SUMW-1:0]  den_reg   [N_DDIV];
    logic [LQW:0]     lrem_reg  [N_DDIV];
    logic [LQW-1:0]   lroot_reg [N_DDIV];
    logic [LQRAD-1:0] lrad_reg  [N_DDIV];
    logic             dnx_reg   [N_DDIV];
    logic             dny_reg   [N_DDIV];
    logic             dzf_reg   [N_DDIV];

    // Direction root section
    logic             qv_reg    [N_DSQ];
    logic [DRW:0]     cqrem_reg [N_DSQ];
    logic [DRW-1:0]   cqrt_reg  [N_DSQ];
    logic [DRAD-1:0]  cqrad_reg [N_DSQ];
    logic [DRW:0]     sqrem_reg [N_DSQ];
    logic [DRW-1:0]   sqrt_reg  [N_DSQ];
    logic [DRAD-1:0]  sqrad_reg [N_DSQ];
    logic [LQW-1:0]   qlq_reg   [N_DSQ];
    logic             qnx_reg   [N_DSQ];
    logic             qny_reg   [N_DSQ];
    logic             qzf_reg   [N_DSQ];

    logic             out_valid_reg;
    polar_word_t      out_word_reg;

    logic [DIRW-1:0]  c_pos;
    logic [DIRW-1:0]  s_pos;

    always_comb
    begin
        init_crem = SUMW'(in_word.ax2[SQW-1:1]);
        init_clow = {in_word.ax2[0], {(DQW-1){1'b0}}};
        init_srem = SUMW'(in_word.ay2[SQW-1:1]);
        init_slow = {in_word.ay2[0], {(DQW-1){1'b0}}};
        init_lrad = LQRAD'({in_word.sum, {(2 * FRAC_BITS){1'b0}}});
        c_pos     = DIRW'(cqrt_reg[N_DSQ-1]);
        s_pos     = DIRW'(sqrt_reg[N_DSQ-1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N_DDIV; i++)
                dv_reg[i] <= 1'b0;
            for (int i = 0; i < N_DSQ; i++)
                qv_reg[i] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            dv_reg[0] <= in_valid;
            for (int i = 1; i < N_DDIV; i++)
                dv_reg[i] <= dv_reg[i-1];
            qv_reg[0] <= dv_reg[N_DDIV-1];
            for (int i = 1; i < N_DSQ; i++)
                qv_reg[i] <= qv_reg[i-1];
            out_valid_reg <= qv_reg[N_DSQ-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            {crem_reg[0], clow_reg[0]} <= ddiv_step(init_crem, init_clow, in_word.sum);
            {srem_reg[0], slow_reg[0]} <= ddiv_step(init_srem, init_slow, in_word.sum);
            {lrem_reg[0], lroot_reg[0], lrad_reg[0]} <= lq_step('0, '0, init_lrad);
            den_reg[0] <= in_word.sum;
            dnx_reg[0] <= in_word.negx;
            dny_reg[0] <= in_word.negy;
            dzf_reg[0] <= (in_word.sum == '0);
            for (int i = 1; i < N_DDIV; i++)
            begin
                {crem_reg[i], clow_reg[i]} <=
                    ddiv_step(crem_reg[i-1], clow_reg[i-1], den_reg[i-1]);
                {srem_reg[i], slow_reg[i]} <=
                    ddiv_step(srem_reg[i-1], slow_reg[i-1], den_reg[i-1]);
                if (i < N_LQ)
                    {lrem_reg[i], lroot_reg[i], lrad_reg[i]} <=
                        lq_step(lrem_reg[i-1], lroot_reg[i-1], lrad_reg[i-1]);
                else
                begin
                    lrem_reg[i]  <= lrem_reg[i-1];
                    lroot_reg[i] <= lroot_reg[i-1];
                    lrad_reg[i]  <= lrad_reg[i-1];
                end
                den_reg[i] <= den_reg[i-1];
                dnx_reg[i] <= dnx_reg[i-1];
                dny_reg[i] <= dny_reg[i-1];
                dzf_reg[i] <= dzf_reg[i-1];
            end

            {cqrem_reg[0], cqrt_reg[0], cqrad_reg[0]} <=
                dsq_step('0, '0, DRAD'(clow_reg[N_DDIV-1]));
            {sqrem_reg[0], sqrt_reg[0], sqrad_reg[0]} <=
                dsq_step('0, '0, DRAD'(slow_reg[N_DDIV-1]));
            qlq_reg[0] <= lroot_reg[N_DDIV-1];
            qnx_reg[0] <= dnx_reg[N_DDIV-1];
            qny_reg[0] <= dny_reg[N_DDIV-1];
            qzf_reg[0] <= dzf_reg[N_DDIV-1];
            for (int i = 1; i < N_DSQ; i++)
            begin
                {cqrem_reg[i], cqrt_reg[i], cqrad_reg[i]} <=
                    dsq_step(cqrem_reg[i-1], cqrt_reg[i-1], cqrad_reg[i-1]);
                {sqrem_reg[i], sqrt_reg[i], sqrad_reg[i]} <=
                    dsq_step(sqrem_reg[i-1], sqrt_reg[i-1], sqrad_reg[i-1]);
                qlq_reg[i] <= qlq_reg[i-1];
                qnx_reg[i] <= qnx_reg[i-1];
                qny_reg[i] <= qny_reg[i-1];
                qzf_reg[i] <= qzf_reg[i-1];
            end

            // centered stick has no direction
            if (qzf_reg[N_DSQ-1])
            begin
                out_word_reg.c <= '0;
                out_word_reg.s <= '0;
            end
            else
            begin
                out_word_reg.c <= qnx_reg[N_DSQ-1] ? (~c_pos + 1'b1) : c_pos;
                out_word_reg.s <= qny_reg[N_DSQ-1] ? (~s_pos + 1'b1) : s_pos;
            end
            out_word_reg.lq <= qlq_reg[N_DSQ-1];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

/* hdl/jpn_gate.sv */
module jpn_gate import jpn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  cfg_t        cfg,
    input  logic        in_valid,
    input  polar_word_t in_word,
    output logic        out_valid,
    output gate_word_t  out_word
);

    // One restoring division step of the sector base
    function automatic logic [BDW+BNW-1:0] bdiv_step(
        input logic [BDW-1:0] rem,
        input logic [BNW-1:0] low,
        input logic [BDW-1:0] den
    );
        logic [BDW:0] t;
        logic         q;
        t = {rem, low[BNW-1]};
        q = (t >= {1'b0, den});
        if (q)
            t = t - {1'b0, den};
        return {t[BDW-1:0], low[BNW-2:0], q};
    endfunction

    // Config-derived terms, static while items flow
    logic [SUMW-1:0]        rr_reg;
    logic [SQW-1:0]         ry2_reg;
    logic signed [OFFD-1:0] dox_reg;
    logic signed [OFFD-1:0] doy_reg;
    logic [RW-1:0]          rmin;

    logic [DIRW-1:0] cu;
    logic [DIRW-1:0] su;
    logic [DIRW-1:0] ac_w;
    logic [DIRW-1:0] as_w;

    // Stage 1: magnitudes and near-axis flags
    logic                   g1_valid_reg;
    logic signed [DIRW-1:0] g1_c_reg;
    logic signed [DIRW-1:0] g1_s_reg;
    logic [LQW-1:0]         g1_lq_reg;
    logic [DRW-1:0]         g1_ac_reg;
    logic [DRW-1:0]         g1_as_reg;
    logic                   g1_sc_reg;
    logic                   g1_ss_reg;

    // Stage 2: products
    logic                   g2_valid_reg;
    logic signed [DIRW-1:0] g2_c_reg;
    logic signed [DIRW-1:0] g2_s_reg;
    logic [LQW-1:0]         g2_lq_reg;
    logic [DRW-1:0]         g2_ac_reg;
    logic [DRW-1:0]         g2_as_reg;
    logic                   g2_sc_reg;
    logic                   g2_ss_reg;
    logic [2*DRW-1:0]       g2_as2_reg;
    logic signed [PW-1:0]   g2_px_reg;
    logic signed [PW-1:0]   g2_py_reg;

    // Stage 3: sector product and correction sum
    logic                   g3_valid_reg;
    logic signed [DIRW-1:0] g3_c_reg;
    logic signed [DIRW-1:0] g3_s_reg;
    logic [LQW-1:0]         g3_lq_reg;
    logic [DRW-1:0]         g3_ac_reg;
    logic [DRW-1:0]         g3_as_reg;
    logic                   g3_sc_reg;
    logic                   g3_ss_reg;
    logic [PRW-1:0]         g3_prod_reg;
    logic [CORRW-1:0]       g3_corr_reg;

    // Sector select
    logic                   sector;

    // Base division section
    logic                   bv_reg    [N_BDIV];
    logic [BDW-1:0]         brem_reg  [N_BDIV];
    logic [BNW-1:0]         blow_reg  [N_BDIV];
    logic [BDW-1:0]         bden_reg  [N_BDIV];
    logic                   bneg_reg  [N_BDIV];
    logic [CORRW-1:0]       bcorr_reg [N_BDIV];
    logic                   bsm_reg   [N_BDIV];
    logic [MW-1:0]          bmsm_reg  [N_BDIV];
    logic signed [DIRW-1:0] bc_reg    [N_BDIV];
    logic signed [DIRW-1:0] bs_reg    [N_BDIV];
    logic [LQW-1:0]         blq_reg   [N_BDIV];

    logic [BDW-1:0]         b0_den;
    logic [BNW-1:0]         b0_num;
    logic                   b0_neg;
    logic [MW-1:0]          b0_msm;

    // Correction add and magnitude
    logic                   e1_valid_reg;
    logic [TW-1:0]          e1_t_reg;
    logic                   e1_sm_reg;
    logic [MW-1:0]          e1_msm_reg;
    logic signed [DIRW-1:0] e1_c_reg;
    logic signed [DIRW-1:0] e1_s_reg;
    logic [LQW-1:0]         e1_lq_reg;
    logic [TW-1:0]          tb;
    logic [TW-1:0]          t_abs;

    logic                   out_valid_reg;
    gate_word_t             out_word_reg;

    always_comb
    begin
        rmin = (cfg.reach_x < cfg.reach_y) ? cfg.reach_x : cfg.reach_y;
        cu   = in_word.c;
        su   = in_word.s;
        ac_w = cu[DIRW-1] ? (~cu + 1'b1) : cu;
        as_w = su[DIRW-1] ? (~su + 1'b1) : su;

        sector = g3_prod_reg < PRW'({ry2_reg, {(2 * FRAC_BITS){1'b0}}});
        b0_num = sector ? {cfg.reach_x, {(2 * FRAC_BITS){1'b0}}}
                        : {cfg.reach_y, {(2 * FRAC_BITS){1'b0}}};
        b0_den = sector ? g3_ac_reg : g3_as_reg;
        b0_neg = sector ? g3_c_reg[DIRW-1] : g3_s_reg[DIRW-1];
        if (g3_sc_reg && g3_ss_reg)
            b0_msm = MW'({rmin, {FRAC_BITS{1'b0}}});
        else if (g3_ss_reg)
            b0_msm = MW'({cfg.reach_x, {FRAC_BITS{1'b0}}});
        else
            b0_msm = MW'({cfg.reach_y, {FRAC_BITS{1'b0}}});

        tb    = {2'b00, blow_reg[N_BDIV-1]};
        t_abs = e1_t_reg[TW-1] ? (~e1_t_reg + 1'b1) : e1_t_reg;
    end

    always_ff @(posedge clk)
    begin
        rr_reg  <= SUMW'(SQW'(cfg.reach_x) * SQW'(cfg.reach_x))
                 + SUMW'(SQW'(cfg.reach_y) * SQW'(cfg.reach_y));
        ry2_reg <= SQW'(cfg.reach_y) * SQW'(cfg.reach_y);
        dox_reg <= {1'b0, cfg.offset_x} - {1'b0, cfg.reach_x};
        doy_reg <= {1'b0, cfg.offset_y} - {1'b0, cfg.reach_y};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g1_valid_reg <= 1'b0;
            g2_valid_reg <= 1'b0;
            g3_valid_reg <= 1'b0;
            for (int i = 0; i < N_BDIV; i++)
                bv_reg[i] <= 1'b0;
            e1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            g1_valid_reg <= in_valid;
            g2_valid_reg <= g1_valid_reg;
            g3_valid_reg <= g2_valid_reg;
            bv_reg[0]    <= g3_valid_reg;
            for (int i = 1; i < N_BDIV; i++)
                bv_reg[i] <= bv_reg[i-1];
            e1_valid_reg  <= bv_reg[N_BDIV-1];
            out_valid_reg <= e1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g1_c_reg  <= in_word.c;
            g1_s_reg  <= in_word.s;
            g1_lq_reg <= in_word.lq;
            g1_ac_reg <= ac_w[DRW-1:0];
            g1_as_reg <= as_w[DRW-1:0];
            g1_sc_reg <= (SMW'(ac_w[DRW-1:0]) * SMW'(SMALL_MUL)) < SMW'(ONE);
            g1_ss_reg <= (SMW'(as_w[DRW-1:0]) * SMW'(SMALL_MUL)) < SMW'(ONE);

            g2_c_reg   <= g1_c_reg;
            g2_s_reg   <= g1_s_reg;
            g2_lq_reg  <= g1_lq_reg;
            g2_ac_reg  <= g1_ac_reg;
            g2_as_reg  <= g1_as_reg;
            g2_sc_reg  <= g1_sc_reg;
            g2_ss_reg  <= g1_ss_reg;
            g2_as2_reg <= (2*DRW)'(g1_as_reg) * (2*DRW)'(g1_as_reg);
            g2_px_reg  <= dox_reg * g1_c_reg;
            g2_py_reg  <= doy_reg * g1_s_reg;

            g3_c_reg    <= g2_c_reg;
            g3_s_reg    <= g2_s_reg;
            g3_lq_reg   <= g2_lq_reg;
            g3_ac_reg   <= g2_ac_reg;
            g3_as_reg   <= g2_as_reg;
            g3_sc_reg   <= g2_sc_reg;
            g3_ss_reg   <= g2_ss_reg;
            g3_prod_reg <= PRW'(g2_as2_reg) * PRW'(rr_reg);
            g3_corr_reg <= {g2_px_reg[PW-1], g2_px_reg} + {g2_py_reg[PW-1], g2_py_reg};

            {brem_reg[0], blow_reg[0]} <= bdiv_step('0, b0_num, b0_den);
            bden_reg[0]  <= b0_den;
            bneg_reg[0]  <= b0_neg;
            bcorr_reg[0] <= g3_corr_reg;
            bsm_reg[0]   <= g3_sc_reg || g3_ss_reg;
            bmsm_reg[0]  <= b0_msm;
            bc_reg[0]    <= g3_c_reg;
            bs_reg[0]    <= g3_s_reg;
            blq_reg[0]   <= g3_lq_reg;
            for (int i = 1; i < N_BDIV; i++)
            begin
                {brem_reg[i], blow_reg[i]} <=
                    bdiv_step(brem_reg[i-1], blow_reg[i-1], bden_reg[i-1]);
                bden_reg[i]  <= bden_reg[i-1];
                bneg_reg[i]  <= bneg_reg[i-1];
                bcorr_reg[i] <= bcorr_reg[i-1];
                bsm_reg[i]   <= bsm_reg[i-1];
                bmsm_reg[i]  <= bmsm_reg[i-1];
                bc_reg[i]    <= bc_reg[i-1];
                bs_reg[i]    <= bs_reg[i-1];
                blq_reg[i]   <= blq_reg[i-1];
            end

            e1_t_reg   <= (bneg_reg[N_BDIV-1] ? (~tb + 1'b1) : tb)
                        + TW'({{(TW-CORRW){bcorr_reg[N_BDIV-1][CORRW-1]}},
                               bcorr_reg[N_BDIV-1]});
            e1_sm_reg  <= bsm_reg[N_BDIV-1];
            e1_msm_reg <= bmsm_reg[N_BDIV-1];
            e1_c_reg   <= bc_reg[N_BDIV-1];
            e1_s_reg   <= bs_reg[N_BDIV-1];
            e1_lq_reg  <= blq_reg[N_BDIV-1];

            out_word_reg.m  <= e1_sm_reg ? e1_msm_reg : t_abs[MW-1:0];
            out_word_reg.c  <= e1_c_reg;
            out_word_reg.s  <= e1_s_reg;
            out_word_reg.lq <= e1_lq_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

/* hdl/jpn_amp.sv */
module jpn_amp import jpn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       adv,
    input  logic       in_valid,
    input  gate_word_t in_word,
    output logic       out_valid,
    output result_t    out_word
);

    function automatic logic [MW+KW-1:0] kdiv_step(
        input logic [MW-1:0] rem,
        input logic [KW-1:0] low,
        input logic [MW-1:0] den
    );
        logic [MW:0] t;
        logic        q;
        t = {rem, low[KW-1]};
        q = (t >= {1'b0, den});
        if (q)
            t = t - {1'b0, den};
        return {t[MW-1:0], low[KW-2:0], q};
    endfunction

    logic [KNW-1:0] num;

    logic                   a1_valid_reg;
    logic [MW-1:0]          a1_rem_reg;
    logic [KW-1:0]          a1_low_reg;
    logic [MW-1:0]          a1_den_reg;
    logic                   a1_ovf_reg;
    logic signed [DIRW-1:0] a1_c_reg;
    logic signed [DIRW-1:0] a1_s_reg;
    logic [MAGW-1:0]        a1_mag_reg;

    logic                   kv_reg   [N_KDIV];
    logic [MW-1:0]          krem_reg [N_KDIV];
    logic [KW-1:0]          klow_reg [N_KDIV];
    logic [MW-1:0]          kden_reg [N_KDIV];
    logic                   kovf_reg [N_KDIV];
    logic signed [DIRW-1:0] kc_reg   [N_KDIV];
    logic signed [DIRW-1:0] ks_reg   [N_KDIV];
    logic [MAGW-1:0]        kmag_reg [N_KDIV];

    logic    out_valid_reg;
    result_t out_word_reg;

    assign num = {in_word.lq, {FRAC_BITS{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a1_valid_reg <= 1'b0;
            for (int i = 0; i < N_KDIV; i++)
                kv_reg[i] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a1_valid_reg <= in_valid;
            kv_reg[0]    <= a1_valid_reg;
            for (int i = 1; i < N_KDIV; i++)
                kv_reg[i] <= kv_reg[i-1];
            out_valid_reg <= kv_reg[N_KDIV-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // quotient of 2^KW or more saturates; a zero maximum lands here too
            a1_ovf_reg <= (MW+KW)'(num) >= {in_word.m, {KW{1'b0}}};
            a1_rem_reg <= MW'(num[KNW-1:KW]);
            a1_low_reg <= num[KW-1:0];
            a1_den_reg <= in_word.m;
            a1_c_reg   <= in_word.c;
            a1_s_reg   <= in_word.s;
            a1_mag_reg <= in_word.lq[LQW-1:FRAC_BITS];

            {krem_reg[0], klow_reg[0]} <= kdiv_step(a1_rem_reg, a1_low_reg, a1_den_reg);
            kden_reg[0] <= a1_den_reg;
            kovf_reg[0] <= a1_ovf_reg;
            kc_reg[0]   <= a1_c_reg;
            ks_reg[0]   <= a1_s_reg;
            kmag_reg[0] <= a1_mag_reg;
            for (int i = 1; i < N_KDIV; i++)
            begin
                {krem_reg[i], klow_reg[i]} <=
                    kdiv_step(krem_reg[i-1], klow_reg[i-1], kden_reg[i-1]);
                kden_reg[i] <= kden_reg[i-1];
                kovf_reg[i] <= kovf_reg[i-1];
                kc_reg[i]   <= kc_reg[i-1];
                ks_reg[i]   <= ks_reg[i-1];
                kmag_reg[i] <= kmag_reg[i-1];
            end

            out_word_reg.amp_factor <= kovf_reg[N_KDIV-1] ? {KW{1'b1}} : klow_reg[N_KDIV-1];
            out_word_reg.dir_cos    <= kc_reg[N_KDIV-1];
            out_word_reg.dir_sin    <= ks_reg[N_KDIV-1];
            out_word_reg.magnitude  <= kmag_reg[N_KDIV-1];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // no direction only for a centered stick
    a_centered_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_word_reg.dir_cos == '0 && out_word_reg.dir_sin == '0)
        |-> out_word_reg.magnitude == '0)
        else $error("direction zero with nonzero length");

    a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_word_reg.dir_cos <= DIRW'(ONE)
                           && out_word_reg.dir_cos >= -DIRW'(ONE)))
        else $error("direction cosine out of range");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !adv) |=> (out_valid_reg && $stable(out_word_reg)))
        else $error("result lost during stall");

endmodule

/* hdl/joystick_polar_normalizer_core.sv */
// Joystick square-gate to polar normalizer.
//
// Input stream (s_*): one word per raw converter pair. Output stream (m_*):
// one word per input word, in order, carrying the amplitude factor K (Q2.14,
// saturating), direction cosine and sine (signed Q1.14) and the integer
// length of the dead-zoned deviation.
// Configuration: write offsets, dead zones, gate reach and axis enables over
// cfg_we/cfg_addr/cfg_wdata while no word is in flight.
//
// Throughput: one word per cycle while the receiver is not stalling. Stages:
// 3 front stages, 29 direction-division and 15 square-root
// stages plus one output register (length root runs alongside), 43 gate
// stages around a 38-step base divider, and 18 stages for the K divider
// plus the output register.
// The restoring dividers and root units, one digit per stage, set the depth.
//
// Reset clears all valid bits and loads the register defaults (offsets and
// reach 512, dead zones 0, both axes on). When the receiver stalls the whole
// pipeline holds; s_tready drops in the same cycle so no word is lost.
module joystick_polar_normalizer_core import jpn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [IN_TDW-1:0]  s_tdata,   // raw_x, raw_y, zero pad
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [OUT_TDW-1:0] m_tdata,   // amp_factor, dir_cos, dir_sin, magnitude, zero pad
    input  logic               cfg_we,
    input  logic [CFG_AW-1:0]  cfg_addr,
    input  logic [CFG_DW-1:0]  cfg_wdata
);

    cfg_t        cfg_reg;
    logic        adv;

    logic        f_valid;
    front_word_t f_word;
    logic        p_valid;
    polar_word_t p_word;
    logic        g_valid;
    gate_word_t  g_word;
    logic        a_valid;
    result_t     a_word;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offset_x <= SAMPLE_BITS'(512);
            cfg_reg.offset_y <= SAMPLE_BITS'(512);
            cfg_reg.dead_x   <= '0;
            cfg_reg.dead_y   <= '0;
            cfg_reg.reach_x  <= SAMPLE_BITS'(512);
            cfg_reg.reach_y  <= SAMPLE_BITS'(512);
            cfg_reg.axis_en  <= 2'b11;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_OFFSET_X: cfg_reg.offset_x <= cfg_wdata;
                REG_OFFSET_Y: cfg_reg.offset_y <= cfg_wdata;
                REG_DEAD_X:   cfg_reg.dead_x   <= cfg_wdata;
                REG_DEAD_Y:   cfg_reg.dead_y   <= cfg_wdata;
                REG_REACH_X:  cfg_reg.reach_x  <= cfg_wdata;
                REG_REACH_Y:  cfg_reg.reach_y  <= cfg_wdata;
                REG_AXIS_EN:  cfg_reg.axis_en  <= cfg_wdata[1:0];
                default:      cfg_reg          <= cfg_reg;
            endcase
        end
    end

    // advance everything unless a finished word is waiting on the receiver
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    jpn_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .raw_x     (s_tdata[SAMPLE_BITS-1:0]),
        .raw_y     (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .cfg       (cfg_reg),
        .out_valid (f_valid),
        .out_word  (f_word)
    );

    jpn_polar u_polar (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (f_valid),
        .in_word   (f_word),
        .out_valid (p_valid),
        .out_word  (p_word)
    );

    jpn_gate u_gate (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .cfg       (cfg_reg),
        .in_valid  (p_valid),
        .in_word   (p_word),
        .out_valid (g_valid),
        .out_word  (g_word)
    );

    jpn_amp u_amp (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (g_valid),
        .in_word   (g_word),
        .out_valid (a_valid),
        .out_word  (a_word)
    );

    assign m_tvalid = a_valid;
    assign m_tdata  = OUT_TDW'(a_word);

endmodule

/* tb/jpn_checker.sv */
module jpn_checker import jpn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [IN_TDW-1:0]  s_tdata,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [OUT_TDW-1:0] m_tdata,
    input  logic               cfg_we,
    input  logic [CFG_AW-1:0]  cfg_addr,
    input  logic [CFG_DW-1:0]  cfg_wdata,
    output int                 errors,
    output int                 pending
);

    cfg_t    regs;
    result_t polar_q[$];

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   -= res + bitv;
                res  = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint dev_of(logic [9:0] raw, logic [9:0] off, logic [9:0] dz,
                                      logic en);
        longint d;
        if (!en)
            return 0;
        d = longint'(raw) - longint'(off);
        if ((d < 0 ? -d : d) <= longint'(dz))
            return 0;
        return d;
    endfunction

    function automatic longint unit_of(longint unsigned a, longint unsigned sum, logic neg);
        longint v;
        if (sum == 0)
            return 0;
        v = longint'(int_sqrt(((a * a) << (2 * FRAC_BITS)) / sum));
        return neg ? -v : v;
    endfunction

    function automatic result_t polar_of(logic [9:0] raw_x, logic [9:0] raw_y);
        longint          dx, dy, c, s, base, corr, t;
        longint unsigned ax, ay, sum, lq, ac, as, rx, ry, m, k;
        logic            small_c, small_s;
        result_t         r;
        dx  = dev_of(raw_x, regs.offset_x, regs.dead_x, regs.axis_en[0]);
        dy  = dev_of(raw_y, regs.offset_y, regs.dead_y, regs.axis_en[1]);
        ax  = dx < 0 ? -dx : dx;
        ay  = dy < 0 ? -dy : dy;
        sum = ax * ax + ay * ay;
        lq  = int_sqrt(sum << (2 * FRAC_BITS));
        c   = unit_of(ax, sum, dx < 0);
        s   = unit_of(ay, sum, dy < 0);
        ac  = c < 0 ? -c : c;
        as  = s < 0 ? -s : s;
        small_c = ac * SMALL_MUL < ONE;
        small_s = as * SMALL_MUL < ONE;
        rx  = regs.reach_x;
        ry  = regs.reach_y;
        if (small_c && small_s)
            m = (rx < ry ? rx : ry) << FRAC_BITS;
        else if (small_s)
            m = rx << FRAC_BITS;
        else if (small_c)
            m = ry << FRAC_BITS;
        else begin
            // pick the gate edge the direction hits first
            if (as * as * (rx * rx + ry * ry) < ((ry * ry) << (2 * FRAC_BITS))) begin
                base = longint'((rx << (2 * FRAC_BITS)) / ac);
                if (c < 0) base = -base;
            end
            else begin
                base = longint'((ry << (2 * FRAC_BITS)) / as);
                if (s < 0) base = -base;
            end
            corr = (longint'(regs.offset_x) - longint'(regs.reach_x)) * c
                 + (longint'(regs.offset_y) - longint'(regs.reach_y)) * s;
            t = base + corr;
            m = t < 0 ? -t : t;
        end
        if (m == 0)
            k = 16'hFFFF;
        else begin
            k = (lq << FRAC_BITS) / m;
            if (k > 16'hFFFF) k = 16'hFFFF;
        end
        r.amp_factor = k[15:0];
        r.dir_cos    = c[15:0];
        r.dir_sin    = s[15:0];
        r.magnitude  = MAGW'(lq >> FRAC_BITS);
        return r;
    endfunction

    assign pending = polar_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        result_t got, want;
        if (!rst_n) begin
            regs   <= '{offset_x: SAMPLE_BITS'(512), offset_y: SAMPLE_BITS'(512),
                        dead_x: '0, dead_y: '0,
                        reach_x: SAMPLE_BITS'(512), reach_y: SAMPLE_BITS'(512),
                        axis_en: 2'b11};
            errors <= 0;
            polar_q.delete();
        end
        else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_OFFSET_X: regs.offset_x <= cfg_wdata;
                    REG_OFFSET_Y: regs.offset_y <= cfg_wdata;
                    REG_DEAD_X:   regs.dead_x   <= cfg_wdata;
                    REG_DEAD_Y:   regs.dead_y   <= cfg_wdata;
                    REG_REACH_X:  regs.reach_x  <= cfg_wdata;
                    REG_REACH_Y:  regs.reach_y  <= cfg_wdata;
                    REG_AXIS_EN:  regs.axis_en  <= cfg_wdata[1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                polar_q.push_back(polar_of(s_tdata[9:0], s_tdata[19:10]));
            if (m_tvalid && m_tready) begin
                got = m_tdata[OUT_FW-1:0];
                if (polar_q.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual %h", $time, got);
                    errors <= errors + 1;
                end
                else begin
                    want = polar_q.pop_front();
                    if (got.amp_factor !== want.amp_factor || got.dir_cos !== want.dir_cos ||
                        got.dir_sin !== want.dir_sin || got.magnitude !== want.magnitude) begin
                        $display({"%0t: mismatch, expected k=%h c=%h s=%h mag=%0d, ",
                                  "actual k=%h c=%h s=%h mag=%0d"},
                                 $time, want.amp_factor, want.dir_cos, want.dir_sin,
                                 want.magnitude, got.amp_factor, got.dir_cos, got.dir_sin,
                                 got.magnitude);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

endmodule

/* tb/testbench.sv */
module testbench;
    import jpn_pkg::*;

    // generous ceiling: ~1100 words with worst-case source gaps and receiver stalls plus pipeline
    localparam int CYCLE_LIMIT = 400000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [IN_TDW-1:0]  s_tdata = '0;    // raw_x, raw_y, zero pad
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [OUT_TDW-1:0] m_tdata;         // amp_factor, dir_cos, dir_sin, magnitude, pad
    logic               cfg_we = 1'b0;
    logic [CFG_AW-1:0]  cfg_addr = '0;
    logic [CFG_DW-1:0]  cfg_wdata = '0;

    int errors, pending;
    int cycles = 0;
    bit calm = 1'b0;     // when set, neither side idles
    int stall_left = 0;

    always #1 clk = ~clk;

    joystick_polar_normalizer_core u_dut (.*);

    jpn_checker u_chk (.*);

    // Receiver: draw a stall per word, drop ready while it runs down.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (m_tvalid && m_tready) begin
            stall_left = calm ? 0 : $urandom_range(0, 12);
            m_tready <= (stall_left == 0);
        end
        else if (stall_left > 0) begin
            stall_left--;
            m_tready <= (stall_left == 0);
        end
        else
            m_tready <= 1'b1;
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[joystick_polar_normalizer_core] ERROR");
            $finish;
        end
    end

    // Write all seven registers back to back, then drop the enable.
    task automatic load_regs(int ox, int oy, int ddx, int ddy, int rx, int ry, int en);
        int vals[7];
        vals = '{ox, oy, ddx, ddy, rx, ry, en};
        for (int i = 0; i < 7; i++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= CFG_AW'(i);
            cfg_wdata <= CFG_DW'(vals[i]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Present one word; valid stays high when no gap follows.
    task automatic send_pair(int x, int y);
        int gap;
        gap = calm ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12));
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, 10'(y), 10'(x)};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // Hold until every expected word is back; the last accepted word is
    // queued by the checker only once the accepting edge has passed.
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        @(posedge clk);
    endtask

    // Samples anywhere, around the rest point and the dead zone edges, and near each axis.
    task automatic random_pairs(int n, int ox, int oy, int dz);
        int x, y;
        for (int i = 0; i < n; i++) begin
            if (i % 80 == 0) calm = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
                0: begin x = $urandom_range(0, 1023); y = $urandom_range(0, 1023); end
                1: begin
                    x = ox + $urandom_range(0, 2 * dz + 4) - dz - 2;
                    y = oy + $urandom_range(0, 2 * dz + 4) - dz - 2;
                end
                2: begin x = $urandom_range(0, 1023); y = oy + $urandom_range(0, 6) - 3; end
                default: begin x = ox + $urandom_range(0, 6) - 3; y = $urandom_range(0, 1023); end
            endcase
            send_pair(x < 0 ? 0 : (x > 1023 ? 1023 : x), y < 0 ? 0 : (y > 1023 ? 1023 : y));
        end
        calm = 1'b0;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: defaults, centred, extremes, near-axis and diagonal directions.
        send_pair(512, 512);
        send_pair(0, 0);
        send_pair(1023, 1023);
        send_pair(0, 1023);
        send_pair(1023, 0);
        send_pair(1023, 512);
        send_pair(512, 0);
        send_pair(1023, 513);
        send_pair(511, 1023);
        send_pair(1023, 515);
        send_pair(700, 800);
        send_pair(300, 150);
        drain();

        // Zero reach gives a saturated factor, also when centred.
        load_regs(0, 1023, 5, 1023, 0, 0, 3);
        send_pair(512, 512);
        send_pair(0, 1023);
        send_pair(1023, 0);
        send_pair(6, 1023);
        drain();

        // Axis enables one at a time, then both off.
        load_regs(512, 512, 0, 0, 1023, 1, 1);
        send_pair(1023, 0);
        send_pair(0, 1023);
        drain();
        load_regs(512, 512, 0, 0, 1, 1023, 2);
        send_pair(1023, 0);
        send_pair(0, 1023);
        drain();
        load_regs(512, 512, 0, 0, 512, 512, 0);
        send_pair(0, 1023);
        drain();

        // Random phases over several settings.
        load_regs(512, 512, 0, 0, 512, 512, 3);
        random_pairs(250, 512, 512, 0);
        drain();
        load_regs(480, 530, 40, 25, 450, 470, 3);
        random_pairs(250, 480, 530, 40);
        drain();
        load_regs(1023, 0, 1023, 0, 1023, 1023, 3);
        random_pairs(100, 1023, 0, 8);
        drain();
        load_regs(0, 1023, 0, 1023, 1, 1, 3);
        random_pairs(100, 0, 1023, 8);
        drain();
        load_regs($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 60),
                  $urandom_range(0, 60), $urandom_range(1, 1023), $urandom_range(1, 1023),
                  $urandom_range(0, 3));
        random_pairs(300, 512, 512, 30);
        drain();

        repeat (150) @(posedge clk);
        if (errors == 0)
            $display("[joystick_polar_normalizer_core] OK");
        else
            $display("[joystick_polar_normalizer_core] ERROR");
        $finish;
    end

endmodule
